[rtl/core/gpio_port_registers_with_lock_defines.svh]
// Assertion macros shared by the GPIO register bank
`ifndef GPIO_PORT_REGISTERS_WITH_LOCK_DEFINES_SVH
`define GPIO_PORT_REGISTERS_WITH_LOCK_DEFINES_SVH

// Condition in this cycle implies a consequence in the same cycle
`define GPL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gpl assertion failed");

// Condition in this cycle implies a consequence in the next cycle
`define GPL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gpl assertion failed");

`endif

[rtl/core/gpl_pkg.sv]
package gpl_pkg;

   // Bus operation codes
   localparam logic [1:0] OP_READ       = 2'd0;
   localparam logic [1:0] OP_WRITE      = 2'd1;
   localparam logic [1:0] OP_SOFT_RESET = 2'd2;

   // Size of the decoded region in bytes
   localparam int RegionBytes = 1024;

   // Register byte offsets
   localparam logic [9:0] OFS_MODE     = 10'h000;
   localparam logic [9:0] OFS_OUT_TYPE = 10'h004;
   localparam logic [9:0] OFS_SPEED    = 10'h008;
   localparam logic [9:0] OFS_PULL     = 10'h00C;
   localparam logic [9:0] OFS_IN_DATA  = 10'h010;
   localparam logic [9:0] OFS_OUT_DATA = 10'h014;
   localparam logic [9:0] OFS_SET_RST  = 10'h018;
   localparam logic [9:0] OFS_LOCK     = 10'h01C;
   localparam logic [9:0] OFS_ALT_LOW  = 10'h020;
   localparam logic [9:0] OFS_ALT_HIGH = 10'h024;

   // Configuration register indexes
   localparam logic [1:0] CSR_MODE_RESET  = 2'd0;
   localparam logic [1:0] CSR_SPEED_RESET = 2'd1;
   localparam logic [1:0] CSR_PULL_RESET  = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [9:0]  byte_offset;
      logic [31:0] write_data;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [15:0] output_pins;
      logic        port_locked;
      logic        access_error;
   } rsp_payload_type;

   typedef struct packed {
      logic [31:0] mode;
      logic [31:0] speed;
      logic [31:0] pull;
   } reset_values_type;

endpackage

[rtl/core/gpl_req_if.sv]
interface gpl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [9:0]  byte_offset;
   logic [31:0] write_data;

   modport source (output valid, output operation, output byte_offset, output write_data,
                   input ready);
   modport sink (input valid, input operation, input byte_offset, input write_data,
                 output ready);
endinterface

[rtl/core/gpl_rsp_if.sv]
interface gpl_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic [15:0] output_pins;
   logic        port_locked;
   logic        access_error;

   modport source (output valid, output read_data, output output_pins, output port_locked,
                   output access_error, input ready);
   modport sink (input valid, input read_data, input output_pins, input port_locked,
                 input access_error, output ready);
endinterface

[rtl/core/gpio_port_registers_with_lock.sv]
// GPIO port register bank with configuration lock. Each request transaction is one 32-bit
// read, write or soft reset and yields exactly one response transaction carrying the read
// data, the output pins after the access, the lock status and an access error flag.
// A transaction is held in the input register and is decoded and applied to the bank as
// it moves to the output register, which offers its response; the move waits while the
// output register still holds a response that has not been taken. One transaction is
// taken every cycle while the response side keeps up.
// Lock sequence at offset 0x1C: write key 1, write key 0, write key 1, then read,
// all with the same pin mask; afterwards mode, type, speed, pull and alternate-function
// writes are dropped until reset. The csr_ registers only set values used by soft reset.
module gpio_port_registers_with_lock (
   input  logic        clock,
   input  logic        reset,
   gpl_req_if.sink     req_chan,
   gpl_rsp_if.source   rsp_chan,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   gpl_pkg::reset_values_type rst_vals_ff;
   gpl_pkg::req_payload_type  req_ff;
   gpl_pkg::req_payload_type  req_in;
   gpl_pkg::rsp_payload_type  rsp_ff;
   gpl_pkg::rsp_payload_type  rsp_in;
   logic                      req_valid_ff;
   logic                      rsp_valid_ff;
   logic                      advance;
   logic                      take;

   // Capture configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rst_vals_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            gpl_pkg::CSR_MODE_RESET:  rst_vals_ff.mode  <= csr_write_data;
            gpl_pkg::CSR_SPEED_RESET: rst_vals_ff.speed <= csr_write_data;
            gpl_pkg::CSR_PULL_RESET:  rst_vals_ff.pull  <= csr_write_data;
            default:                  rst_vals_ff <= rst_vals_ff;
         endcase
      end
   end

   // Move a transaction out of the input register when the output register frees up
   assign advance        = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   assign req_in.operation   = req_chan.operation;
   assign req_in.byte_offset = req_chan.byte_offset;
   assign req_in.write_data  = req_chan.write_data;

   gpl_bank u_bank (
      .clock    (clock),
      .reset    (reset),
      .proc     (advance),
      .req      (req_ff),
      .rst_vals (rst_vals_ff),
      .rsp      (rsp_in)
   );

   // Input and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (take) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.read_data    = rsp_ff.read_data;
   assign rsp_chan.output_pins  = rsp_ff.output_pins;
   assign rsp_chan.port_locked  = rsp_ff.port_locked;
   assign rsp_chan.access_error = rsp_ff.access_error;

endmodule

[rtl/core/gpl_bank.sv]
`include "gpio_port_registers_with_lock_defines.svh"

module gpl_bank (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      proc,
   input  gpl_pkg::req_payload_type  req,
   input  gpl_pkg::reset_values_type rst_vals,
   output gpl_pkg::rsp_payload_type  rsp
);

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_SECOND,
      PH_THIRD,
      PH_READ,
      PH_LOCKED
   } lock_phase_type;

   logic [31:0]    mode_ff, mode_in;
   logic [15:0]    out_type_ff, out_type_in;
   logic [31:0]    speed_ff, speed_in;
   logic [31:0]    pull_ff, pull_in;
   logic [15:0]    out_data_ff, out_data_in;
   logic [16:0]    lock_word_ff, lock_word_in;
   logic [31:0]    alt_low_ff, alt_low_in;
   logic [31:0]    alt_high_ff, alt_high_in;
   lock_phase_type phase_ff, phase_in;

   logic        locked;
   logic        in_range;
   logic        key;
   logic [15:0] mask;
   logic [31:0] rd;
   logic        err;

   assign locked   = (phase_ff == PH_LOCKED);
   assign in_range = ({3'b000, req.byte_offset} < 13'(gpl_pkg::RegionBytes));
   assign key      = req.write_data[16];
   assign mask     = req.write_data[15:0];

   // Decode the transaction and work out next state and read data
   always_comb begin
      mode_in      = mode_ff;
      out_type_in  = out_type_ff;
      speed_in     = speed_ff;
      pull_in      = pull_ff;
      out_data_in  = out_data_ff;
      lock_word_in = lock_word_ff;
      alt_low_in   = alt_low_ff;
      alt_high_in  = alt_high_ff;
      phase_in     = phase_ff;
      rd           = '0;
      err          = 1'b0;
      if (proc) begin
         case (req.operation)
            gpl_pkg::OP_SOFT_RESET: begin
               mode_in      = rst_vals.mode;
               out_type_in  = '0;
               speed_in     = rst_vals.speed;
               pull_in      = rst_vals.pull;
               out_data_in  = '0;
               lock_word_in = '0;
               alt_low_in   = '0;
               alt_high_in  = '0;
               phase_in     = PH_FIRST;
            end
            gpl_pkg::OP_READ: begin
               if (!in_range) begin
                  err = 1'b1;
               end else begin
                  case (req.byte_offset)
                     gpl_pkg::OFS_MODE:     rd = mode_ff;
                     gpl_pkg::OFS_OUT_TYPE: rd = {16'h0000, out_type_ff};
                     gpl_pkg::OFS_SPEED:    rd = speed_ff;
                     gpl_pkg::OFS_PULL:     rd = pull_ff;
                     gpl_pkg::OFS_OUT_DATA: rd = {16'h0000, out_data_ff};
                     gpl_pkg::OFS_SET_RST:  err = 1'b1;
                     gpl_pkg::OFS_LOCK: begin
                        // a read of the lock word completes or breaks the key
                        rd = {15'h0000, lock_word_ff};
                        case (phase_ff)
                           PH_FIRST:  phase_in = PH_FIRST;
                           PH_LOCKED: phase_in = PH_LOCKED;
                           PH_READ:   phase_in = PH_LOCKED;
                           default:   phase_in = PH_FIRST;
                        endcase
                     end
                     gpl_pkg::OFS_ALT_LOW:  rd = alt_low_ff;
                     gpl_pkg::OFS_ALT_HIGH: rd = alt_high_ff;
                     default:               rd = '0;
                  endcase
               end
            end
            gpl_pkg::OP_WRITE: begin
               if (!in_range) begin
                  err = 1'b1;
               end else begin
                  case (req.byte_offset)
                     gpl_pkg::OFS_MODE:     if (!locked) mode_in = req.write_data;
                     gpl_pkg::OFS_OUT_TYPE: if (!locked) out_type_in = mask;
                     gpl_pkg::OFS_SPEED:    if (!locked) speed_in = req.write_data;
                     gpl_pkg::OFS_PULL:     if (!locked) pull_in = req.write_data;
                     gpl_pkg::OFS_IN_DATA:  err = 1'b1;
                     gpl_pkg::OFS_OUT_DATA: out_data_in = mask;
                     // set half wins over clear half
                     gpl_pkg::OFS_SET_RST:
                        out_data_in = (out_data_ff & ~mask) | req.write_data[31:16];
                     gpl_pkg::OFS_LOCK: begin
                        if (!locked) begin
                           if (phase_ff != PH_FIRST && lock_word_ff[15:0] != mask) begin
                              phase_in = PH_FIRST;
                           end else begin
                              case (phase_ff)
                                 PH_FIRST: begin
                                    if (key) begin
                                       lock_word_in = {1'b1, mask};
                                       phase_in     = PH_SECOND;
                                    end
                                 end
                                 PH_SECOND: begin
                                    if (key) begin
                                       phase_in = PH_FIRST;
                                    end else begin
                                       lock_word_in = {1'b0, mask};
                                       phase_in     = PH_THIRD;
                                    end
                                 end
                                 PH_THIRD: begin
                                    if (!key) begin
                                       phase_in = PH_FIRST;
                                    end else begin
                                       lock_word_in = {1'b1, mask};
                                       phase_in     = PH_READ;
                                    end
                                 end
                                 default: phase_in = PH_FIRST;
                              endcase
                           end
                        end
                     end
                     gpl_pkg::OFS_ALT_LOW:  if (!locked) alt_low_in = req.write_data;
                     gpl_pkg::OFS_ALT_HIGH: if (!locked) alt_high_in = req.write_data;
                     default:               rd = '0;
                  endcase
               end
            end
            default: rd = '0;
         endcase
      end
   end

   // Result reflects the state after this transaction
   assign rsp.read_data    = rd;
   assign rsp.output_pins  = out_data_in;
   assign rsp.port_locked  = (phase_in == PH_LOCKED);
   assign rsp.access_error = err;

   // Hold the bank registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= '0;
         out_type_ff  <= '0;
         speed_ff     <= '0;
         pull_ff      <= '0;
         out_data_ff  <= '0;
         lock_word_ff <= '0;
         alt_low_ff   <= '0;
         alt_high_ff  <= '0;
         phase_ff     <= PH_FIRST;
      end else begin
         mode_ff      <= mode_in;
         out_type_ff  <= out_type_in;
         speed_ff     <= speed_in;
         pull_ff      <= pull_in;
         out_data_ff  <= out_data_in;
         lock_word_ff <= lock_word_in;
         alt_low_ff   <= alt_low_in;
         alt_high_ff  <= alt_high_in;
         phase_ff     <= phase_in;
      end
   end

   // Lock holds until a soft reset
   `GPL_ASSERT_NEXT(a_lock_sticky, clock, reset,
      locked && !(proc && req.operation == gpl_pkg::OP_SOFT_RESET), phase_ff == PH_LOCKED)
   // Mode write is dropped while locked
   `GPL_ASSERT_NEXT(a_mode_frozen, clock, reset,
      locked && proc && req.operation == gpl_pkg::OP_WRITE, $stable(mode_ff))
   // Lock is entered only from the read phase
   `GPL_ASSERT_NOW(a_lock_entry, clock, reset,
      phase_ff == PH_LOCKED && $past(phase_ff) != PH_LOCKED, $past(phase_ff) == PH_READ)

endmodule
